@@ rtl/snd_pkg.sv @@
// Shared types, constants and helpers for the 2D simplex noise pipeline.
// No dependencies; imported by every snd_* module and the top level.
package snd_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;                 // fractional bits of the coordinates
  localparam int TBL_AW    = 8;                  // permutation table address bits
  localparam int TBL_SIZE  = 2 ** TBL_AW;
  localparam int CELL_W    = 33 - FRAC_BITS;     // width of the floored cell index
  localparam int CRN_W     = CELL_W + 1;         // cell index plus one
  localparam int T_W       = 33;                 // unskew term width
  localparam int E_W       = 38;                 // raw corner offset width
  localparam int OFF_SH    = 30 - FRAC_BITS;     // Q(FRAC) to Q30 shift
  localparam int SC_W      = E_W + OFF_SH;

  localparam logic [31:0] SKEW_Q32   = 32'd1572067139;
  localparam logic [29:0] UNSKEW_Q32 = 30'd907633386;
  localparam logic [29:0] HALF_Q30   = 30'd536870912;
  localparam logic signed [30:0] RSQ2_Q30 = 31'sd759250125;
  localparam logic signed [SC_W-1:0] OFF_LIM = SC_W'(64'sd2147483647);

  // Item kind carried on tuser
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } act_e;

  // Gradient codes: axis directions, then diagonals
  typedef enum logic [2:0] {
    GR_XP = 3'd0,
    GR_XN = 3'd1,
    GR_YP = 3'd2,
    GR_YN = 3'd3,
    GR_PP = 3'd4,
    GR_NP = 3'd5,
    GR_PN = 3'd6,
    GR_NN = 3'd7
  } grad_e;

  // Sideband that travels with an item through the lattice stages
  typedef struct packed {
    logic             vld;
    act_e             act;
    logic [TBL_AW-1:0] idx;
    logic [7:0]       val;
  } snd_side_t;

  // One corner: Q30 offsets and wrapped lattice coordinates
  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [TBL_AW-1:0]  ci;
    logic [TBL_AW-1:0]  cj;
  } snd_crn_t;

  // Scale a raw offset to Q30 and clamp to +-(2^31-1)
  function automatic logic signed [31:0] sat_off(input logic signed [E_W-1:0] e);
    logic signed [SC_W-1:0] sc;
    sc = {e, {OFF_SH{1'b0}}};
    if (sc > OFF_LIM) begin
      sat_off = 32'sh7FFFFFFF;
    end else if (sc < -OFF_LIM) begin
      sat_off = -32'sh7FFFFFFF;
    end else begin
      sat_off = sc[31:0];
    end
  endfunction

endpackage

@@ rtl/snd_lattice.sv @@
// Skew, cell floor, unskew and corner offsets: five register stages.
// Depends on snd_pkg.
module snd_lattice (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  snd_pkg::snd_side_t        side_i,
  input  logic signed [31:0]        x_i,
  input  logic signed [31:0]        y_i,
  output snd_pkg::snd_side_t        side_o,
  output snd_pkg::snd_crn_t         crn_o [3]
);
  import snd_pkg::*;

  snd_side_t side1_q, side2_q, side3_q, side4_q, side5_q;
  logic signed [31:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [31:0] s1_q;
  logic signed [CELL_W-1:0] i2_q, j2_q, i3_q, j3_q, i4_q, j4_q;
  logic signed [T_W-1:0] t3_q [3];
  logic signed [T_W-1:0] t4_q [3];
  logic lower4_q;
  snd_crn_t crn5_q [3];

  // Stage 1: skew product
  logic signed [32:0] sxy;
  logic signed [64:0] ps;
  assign sxy = {x_i[31], x_i} + {y_i[31], y_i};
  assign ps  = sxy * $signed({1'b0, SKEW_Q32});

  // Stage 2: floored cell
  logic signed [32:0] xs, ys;
  assign xs = {x1_q[31], x1_q} + {s1_q[31], s1_q};
  assign ys = {y1_q[31], y1_q} + {s1_q[31], s1_q};

  // Stage 3: unskew products for corner sums 0, 1, 2
  logic signed [CELL_W:0] sij [3];
  logic signed [CELL_W+31:0] pt [3];
  for (genvar k = 0; k < 3; k++) begin : g_unskew
    assign sij[k] = {i2_q[CELL_W-1], i2_q} + {j2_q[CELL_W-1], j2_q} + (CELL_W+1)'(k);
    assign pt[k]  = sij[k] * $signed({1'b0, UNSKEW_Q32});
  end

  // Stage 4: triangle choice
  logic signed [E_W-1:0] x0, y0;
  assign x0 = E_W'(x3_q) - {{(E_W-CELL_W-FRAC_BITS){i3_q[CELL_W-1]}}, i3_q, {FRAC_BITS{1'b0}}}
            + E_W'(t3_q[0]);
  assign y0 = E_W'(y3_q) - {{(E_W-CELL_W-FRAC_BITS){j3_q[CELL_W-1]}}, j3_q, {FRAC_BITS{1'b0}}}
            + E_W'(t3_q[0]);

  // Stage 5: per-corner offsets
  logic signed [CRN_W-1:0] ci [3];
  logic signed [CRN_W-1:0] cj [3];
  logic signed [E_W-1:0]   ex [3];
  logic signed [E_W-1:0]   ey [3];
  for (genvar k = 0; k < 3; k++) begin : g_corner
    logic a, b;
    assign a = (k == 0) ? 1'b0 : (k == 2) ? 1'b1 : lower4_q;
    assign b = (k == 0) ? 1'b0 : (k == 2) ? 1'b1 : ~lower4_q;
    assign ci[k] = CRN_W'(i4_q) + CRN_W'(a);
    assign cj[k] = CRN_W'(j4_q) + CRN_W'(b);
    assign ex[k] = E_W'(x4_q)
                 - {{(E_W-CRN_W-FRAC_BITS){ci[k][CRN_W-1]}}, ci[k], {FRAC_BITS{1'b0}}}
                 + E_W'(t4_q[k]);
    assign ey[k] = E_W'(y4_q)
                 - {{(E_W-CRN_W-FRAC_BITS){cj[k][CRN_W-1]}}, cj[k], {FRAC_BITS{1'b0}}}
                 + E_W'(t4_q[k]);
  end

  // Sideband registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
    end else if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      side5_q <= side4_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= x_i;
      y1_q <= y_i;
      s1_q <= ps[63:32];
      x2_q <= x1_q;
      y2_q <= y1_q;
      i2_q <= xs[32:FRAC_BITS];
      j2_q <= ys[32:FRAC_BITS];
      x3_q <= x2_q;
      y3_q <= y2_q;
      i3_q <= i2_q;
      j3_q <= j2_q;
      for (int k = 0; k < 3; k++) begin
        t3_q[k] <= pt[k][T_W+31-FRAC_BITS:32-FRAC_BITS];
        t4_q[k] <= t3_q[k];
        crn5_q[k].dx <= sat_off(ex[k]);
        crn5_q[k].dy <= sat_off(ey[k]);
        crn5_q[k].ci <= ci[k][TBL_AW-1:0];
        crn5_q[k].cj <= cj[k][TBL_AW-1:0];
      end
      x4_q <= x3_q;
      y4_q <= y3_q;
      i4_q <= i3_q;
      j4_q <= j3_q;
      lower4_q <= (x0 > y0);
    end
  end

  assign side_o = side5_q;
  assign crn_o  = crn5_q;

endmodule

@@ rtl/snd_hash.sv @@
// Corner hashing: three copies of the permutation table, two reads each.
// Depends on snd_pkg. Loads write all copies in the first read stage.
module snd_hash (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  snd_pkg::snd_side_t   side_i,
  input  snd_pkg::snd_crn_t    crn_i [3],
  output snd_pkg::grad_e       g_o [3]
);
  import snd_pkg::*;

  for (genvar k = 0; k < 3; k++) begin : g_copy
    logic [7:0]        mem [TBL_SIZE];
    logic [TBL_AW-1:0] pa_q;
    logic [TBL_AW-1:0] cj_q;
    grad_e             g_q;

    // One write port, first read by ci, second read by perm[ci] + cj
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (side_i.vld && side_i.act == ACT_LOAD) begin
          mem[side_i.idx] <= side_i.val;
        end
        pa_q <= mem[crn_i[k].ci][TBL_AW-1:0];
        cj_q <= crn_i[k].cj;
        g_q  <= grad_e'(mem[pa_q + cj_q][2:0]);
      end
    end

    assign g_o[k] = g_q;
  end

endmodule

@@ rtl/snd_corner.sv @@
// One corner's contribution: falloff weight to the fourth power times g.d.
// Depends on snd_pkg. Five register stages; gradient enters at stage three.
module snd_corner (
  input  logic                clk_i,
  input  logic                en_i,
  input  snd_pkg::snd_crn_t   crn_i,
  input  snd_pkg::grad_e      g_i,
  output logic signed [31:0]  contrib_o
);
  import snd_pkg::*;

  logic signed [63:0] sqx1_q, sqy1_q;
  logic signed [31:0] dx1_q, dy1_q, dx2_q, dy2_q;
  logic [29:0] w2_q;
  logic [28:0] ww3_q;
  logic signed [32:0] u3_q;
  logic axis3_q;
  logic [26:0] w4_q;
  logic signed [32:0] dot4_q;
  logic signed [31:0] contrib5_q;

  // Stage 2: squared distance and weight (zero outside the radius)
  logic [32:0] d2;
  logic [29:0] w_d;
  assign d2  = {1'b0, sqx1_q[61:30]} + {1'b0, sqy1_q[61:30]};
  assign w_d = (d2 < {3'b0, HALF_Q30}) ? (HALF_Q30 - d2[29:0]) : '0;

  // Stage 3: weight squared, gradient dot operand
  logic [59:0] pw;
  logic signed [32:0] sx, sy, u_d;
  assign pw = w2_q * w2_q;
  assign sx = {dx2_q[31], dx2_q};
  assign sy = {dy2_q[31], dy2_q};
  always_comb begin
    unique case (g_i)
      GR_XP:   u_d = sx;
      GR_XN:   u_d = -sx;
      GR_YP:   u_d = sy;
      GR_YN:   u_d = -sy;
      GR_PP:   u_d = sx + sy;
      GR_NP:   u_d = sy - sx;
      GR_PN:   u_d = sx - sy;
      GR_NN:   u_d = -sx - sy;
      default: u_d = '0;
    endcase
  end

  // Stage 4: weight to the fourth, diagonal scaling
  logic [57:0] pw4;
  logic signed [63:0] rp;
  assign pw4 = ww3_q * ww3_q;
  assign rp  = u3_q * RSQ2_Q30;

  // Stage 5: contribution
  logic signed [61:0] cp;
  assign cp = $signed({1'b0, w4_q}) * dot4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx1_q     <= crn_i.dx * crn_i.dx;
      sqy1_q     <= crn_i.dy * crn_i.dy;
      dx1_q      <= crn_i.dx;
      dy1_q      <= crn_i.dy;
      w2_q       <= w_d;
      dx2_q      <= dx1_q;
      dy2_q      <= dy1_q;
      ww3_q      <= pw[58:30];
      u3_q       <= u_d;
      axis3_q    <= ~g_i[2];
      w4_q       <= pw4[56:30];
      dot4_q     <= axis3_q ? u3_q : rp[62:30];
      contrib5_q <= cp[61:30];
    end
  end

  assign contrib_o = contrib5_q;

endmodule

@@ rtl/simplex_noise_2d_top.sv @@
// Top level of the 2D simplex noise evaluator.
// Depends on snd_pkg, snd_lattice, snd_hash and snd_corner.
//
//   port group   dir  carries
//   s_axis_*     in   load (tuser 0) or evaluate (tuser 1) request
//   m_axis_*     out  noise sum for each evaluate request
//
// One request per cycle unless a held result stalls; a result is registered through the
// 5 lattice stages, 5 corner stages and the output register after its request is taken.
// Load requests write the table after the lattice stages and return nothing.
// All stages advance together; a held result with tready low freezes them.
// Reset clears the valid bits; the table is undefined until loaded.
module simplex_noise_2d_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry_index, [15:8] entry_value, [47:16] coord_x, [79:48] coord_y
  input  logic [79:0] s_axis_tdata,
  // [0] action
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] noise_value
  output logic [31:0] m_axis_tdata
);
  import snd_pkg::*;

  logic en;
  logic out_vld_q;
  logic [31:0] out_data_q;
  logic [4:0] vld_q;
  snd_side_t side_in, side5;
  snd_crn_t  crn5 [3];
  grad_e     g [3];
  logic signed [31:0] contrib [3];

  // Whole pipeline moves unless a result is held
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  assign side_in.vld = s_axis_tvalid & en;
  assign side_in.act = act_e'(s_axis_tuser);
  assign side_in.idx = s_axis_tdata[7:0];
  assign side_in.val = s_axis_tdata[15:8];

  snd_lattice u_lattice (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_in),
    .x_i    ($signed(s_axis_tdata[47:16])),
    .y_i    ($signed(s_axis_tdata[79:48])),
    .side_o (side5),
    .crn_o  (crn5)
  );

  snd_hash u_hash (
    .clk_i  (clk_i),
    .en_i   (en),
    .side_i (side5),
    .crn_i  (crn5),
    .g_o    (g)
  );

  for (genvar k = 0; k < 3; k++) begin : g_crn
    snd_corner u_corner (
      .clk_i     (clk_i),
      .en_i      (en),
      .crn_i     (crn5[k]),
      .g_i       (g[k]),
      .contrib_o (contrib[k])
    );
  end

  // Evaluate-valid chain alongside the corner stages, then output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[3:0], side5.vld & (side5.act == ACT_EVAL)};
      out_vld_q <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= contrib[0] + contrib[1] + contrib[2];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Stall freezes the evaluate chain
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid chain moved during stall");

  // Last corner stage holding an evaluate yields a result
  a_eval_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[4] |=> out_vld_q)
    else $error("evaluate lost at output");

  // Nothing else yields a result
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !vld_q[4] |=> !out_vld_q)
    else $error("result without evaluate");

  // Loads never enter the evaluate chain
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && side5.vld && side5.act == ACT_LOAD |=> !vld_q[0])
    else $error("load marked as evaluate");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for simplex_noise_2d_top: loads the permutation table,
// predicts each noise sum in fixed point and checks the output stream in order.
// Depends on snd_pkg and the RTL of the noise evaluator.
module tb;
  import snd_pkg::*;

  localparam longint SKEW_K   = 64'sd1572067139;
  localparam longint UNSKEW_K = 64'sd907633386;
  localparam longint HALF_K   = 64'sd536870912;
  localparam longint ONE_K    = 64'sd1073741824;
  localparam longint RSQ2_K   = 64'sd759250125;
  localparam longint OFF_MAX  = 64'sd2147483647;
  localparam int     LIMIT    = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = ACT_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [7:0]  perm_shadow [TBL_SIZE];
  logic [31:0] noise_q [$];
  bit          calm = 1'b0;
  int          errors = 0;
  int          n_loads = 0;
  int          n_evals = 0;
  int          n_checked = 0;
  int          cycles = 0;

  simplex_noise_2d_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 13);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [31:0] exp_v;
        exp_v = noise_q.pop_front();
        n_checked++;
        if (exp_v !== m_axis_tdata) begin
          $display("%0t: noise_value expected %h actual %h", $time, exp_v, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // One corner contribution, Q30
  function automatic longint corner_q30(longint x, longint y, longint ci, longint cj);
    longint t, dx, dy, d2, w, w2, w4, gx, gy, dot;
    logic [7:0] a, b;
    grad_e g;
    t  = ((ci + cj) * UNSKEW_K) >>> (32 - FRAC_BITS);
    dx = (x - ci * (64'sd1 << FRAC_BITS) + t) * (64'sd1 << (30 - FRAC_BITS));
    dy = (y - cj * (64'sd1 << FRAC_BITS) + t) * (64'sd1 << (30 - FRAC_BITS));
    dx = dx > OFF_MAX ? OFF_MAX : (dx < -OFF_MAX ? -OFF_MAX : dx);
    dy = dy > OFF_MAX ? OFF_MAX : (dy < -OFF_MAX ? -OFF_MAX : dy);
    d2 = ((dx * dx) >>> 30) + ((dy * dy) >>> 30);
    if (d2 >= HALF_K) return 0;
    w  = HALF_K - d2;
    w2 = (w * w) >>> 30;
    w4 = (w2 * w2) >>> 30;
    // negative cells wrap through their low bits
    a = 8'(ci);
    b = 8'(perm_shadow[a] + 8'(cj));
    g = grad_e'(perm_shadow[b][2:0]);
    case (g)
      GR_XP:   begin gx = ONE_K;   gy = 0;       end
      GR_XN:   begin gx = -ONE_K;  gy = 0;       end
      GR_YP:   begin gx = 0;       gy = ONE_K;   end
      GR_YN:   begin gx = 0;       gy = -ONE_K;  end
      GR_PP:   begin gx = RSQ2_K;  gy = RSQ2_K;  end
      GR_NP:   begin gx = -RSQ2_K; gy = RSQ2_K;  end
      GR_PN:   begin gx = RSQ2_K;  gy = -RSQ2_K; end
      default: begin gx = -RSQ2_K; gy = -RSQ2_K; end
    endcase
    dot = (gx * dx + gy * dy) >>> 30;
    return (w4 * dot) >>> 30;
  endfunction

  // Noise sum over the three triangle corners
  function automatic logic [31:0] noise_at(logic signed [31:0] xs, logic signed [31:0] ys);
    longint x, y, s, i, j, t, x0, y0, sum;
    bit lower;
    x = xs;
    y = ys;
    s = ((x + y) * SKEW_K) >>> 32;
    i = (x + s) >>> FRAC_BITS;
    j = (y + s) >>> FRAC_BITS;
    t = ((i + j) * UNSKEW_K) >>> (32 - FRAC_BITS);
    x0 = x - i * (64'sd1 << FRAC_BITS) + t;
    y0 = y - j * (64'sd1 << FRAC_BITS) + t;
    lower = x0 > y0;
    sum = corner_q30(x, y, i, j)
        + corner_q30(x, y, i + (lower ? 1 : 0), j + (lower ? 0 : 1))
        + corner_q30(x, y, i + 1, j + 1);
    return sum[31:0];
  endfunction

  // Send one request; predict at acceptance
  task automatic send_req(act_e act, logic [7:0] idx, logic [7:0] val,
                          logic [31:0] x, logic [31:0] y);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {y, x, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == ACT_LOAD) begin
      perm_shadow[idx] = val;
      n_loads++;
    end else begin
      noise_q.push_back(noise_at(x, y));
      n_evals++;
    end
  endtask

  task automatic eval_at(logic [31:0] x, logic [31:0] y);
    send_req(ACT_EVAL, 8'($urandom), 8'($urandom), x, y);
  endtask

  // Hold off the sender until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (noise_q.size() != 0) @(posedge clk_i);
  endtask

  // Load a shuffled permutation into every entry
  task automatic test_table_load();
    logic [7:0] p [TBL_SIZE];
    logic [7:0] tmp;
    int k;
    for (int n = 0; n < TBL_SIZE; n++) p[n] = 8'(n);
    for (int n = TBL_SIZE - 1; n > 0; n--) begin
      k = $urandom_range(n);
      tmp = p[n]; p[n] = p[k]; p[k] = tmp;
    end
    for (int n = 0; n < TBL_SIZE; n++)
      send_req(ACT_LOAD, 8'(n), p[n], $urandom, $urandom);
  endtask

  // Extremes, lattice points, both triangles, negative cells
  task automatic test_directed();
    eval_at(32'h0, 32'h0);
    eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(32'h8000_0000, 32'h8000_0000);
    eval_at(32'h8000_0000, 32'h7FFF_FFFF);
    eval_at(32'h7FFF_FFFF, 32'h8000_0000);
    eval_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    eval_at(32'h0001_0000, 32'h0000_4000);   // upper triangle
    eval_at(32'h0000_4000, 32'h0001_0000);   // lower triangle
    eval_at(32'h0000_8000, 32'h0000_8000);   // on the diagonal
    eval_at(32'hFFFE_8000, 32'hFFFD_2000);   // negative cells wrap
    eval_at(32'h0123_4567, 32'hFEDC_BA98);
    eval_at(32'h00FF_0000, 32'h0100_0000);   // cell index crosses the table size
    eval_at(32'h0000_0001, 32'h0000_0000);
    eval_at(32'h5555_5555, 32'hAAAA_AAAA);
    eval_at(32'hAAAA_AAAA, 32'h5555_5555);
    // reload an entry and use it right away
    send_req(ACT_LOAD, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    eval_at(32'h0000_2000, 32'h0000_1000);
    send_req(ACT_LOAD, 8'h00, 8'h00, 32'h0, 32'h0);
    eval_at(32'h0000_2000, 32'h0000_1000);
  endtask

  // Mostly evaluations near the origin, some full range, some table rewrites
  task automatic test_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_req(ACT_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
      end else if (r < 30) begin
        eval_at($urandom, $urandom);
      end else begin
        eval_at(32'($signed(20'($urandom))), 32'($signed(20'($urandom))));
      end
      if (n == count / 2) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed();
    drain();
    calm = 1'b1;                 // back-to-back stretch
    test_random(100);
    calm = 1'b0;
    test_random(125);
    s_axis_tvalid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d table loads and %0d noise evaluations, %0d results checked",
             n_loads, n_evals, n_checked);
    $display("errors: %0d", errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
